FILE: rtl/assert_macros.svh
// Assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

FILE: rtl/ep0_pkg.sv
// Shared types and constants for the EP0 control sequencer
package ep0_pkg;
    localparam int MAX_PACKET_DEF     = 64;
    localparam int NUM_ENDPOINTS_DEF  = 16;
    localparam int MAX_INTERFACES_DEF = 8;

    localparam logic [1:0] KIND_SETUP = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_RESET = 2'd2;

    localparam logic [2:0] ACT_NONE     = 3'd0;
    localparam logic [2:0] ACT_SEND_IN  = 3'd1;
    localparam logic [2:0] ACT_ARM_OUT  = 3'd2;
    localparam logic [2:0] ACT_STALL    = 3'd3;
    localparam logic [2:0] ACT_FWD_REQ  = 3'd4;
    localparam logic [2:0] ACT_FWD_DATA = 3'd5;
    localparam logic [2:0] ACT_ADDRESS  = 3'd6;
    localparam logic [2:0] ACT_NOTIFY   = 3'd7;

    localparam logic [2:0] SRC_DEVICE = 3'd0;
    localparam logic [2:0] SRC_CONFIG = 3'd1;
    localparam logic [2:0] SRC_STRING = 3'd2;
    localparam logic [2:0] SRC_ZERO   = 3'd3;
    localparam logic [2:0] SRC_HID    = 3'd4;
    localparam logic [2:0] SRC_NONE   = 3'd5;

    localparam logic [1:0] REG_DEVICE_LEN = 2'd0;
    localparam logic [1:0] REG_CONFIG_LEN = 2'd1;
    localparam logic [1:0] REG_HID_LEN    = 2'd2;

    localparam logic [7:0] REQ_GET_STATUS     = 8'h00;
    localparam logic [7:0] REQ_CLEAR_FEATURE  = 8'h01;
    localparam logic [7:0] REQ_SET_ADDRESS    = 8'h05;
    localparam logic [7:0] REQ_GET_DESCRIPTOR = 8'h06;
    localparam logic [7:0] REQ_SET_CONFIG     = 8'h09;
    localparam logic [7:0] REQ_SET_INTERFACE  = 8'h0B;

    localparam logic [11:0] STRING_DESC_LEN = 12'd12;
    localparam logic [6:0]  CLEAR_EP_LEN    = 7'd16;

    // Classified operation handed from front to back
    typedef enum logic [3:0] {
        OP_NONE,
        OP_STALL,
        OP_START_IN,
        OP_SET_ADDR,
        OP_SET_CONF,
        OP_ACK,
        OP_CLEAR_EP2,
        OP_FWD_IN,
        OP_FWD_OUT0,
        OP_ARM_DATA,
        OP_EP0_IN_DONE,
        OP_EP0_OUT_DONE,
        OP_NOTIFY_EP,
        OP_BUS_RESET
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [2:0]  src;
        logic [11:0] len;
        logic [6:0]  addr;
        logic        conf;
        logic [3:0]  ep;
        logic        dir_in;
        logic [6:0]  dlen;
        logic        accepts;
        logic [7:0]  rt;
        logic [7:0]  itf;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [2:0]  data_source;
        logic [11:0] byte_offset;
        logic [6:0]  packet_len;
        logic        data_pid;
        logic [3:0]  target_ep;
        logic        target_in;
        logic [6:0]  new_address;
        logic        is_configured;
        logic        last_result;
    } res_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_R1,
        ST_R2
    } bstate_t;
endpackage

FILE: rtl/ep0_front.sv
// Front end: latches config registers and classifies control events
module ep0_front
    import ep0_pkg::*;
#(
    parameter int MAX_PACKET     = MAX_PACKET_DEF,
    parameter int NUM_ENDPOINTS  = NUM_ENDPOINTS_DEF,
    parameter int MAX_INTERFACES = MAX_INTERFACES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data,
    input  logic [1:0]  req_type,
    input  logic [7:0]  request_type_byte,
    input  logic [7:0]  request_code,
    input  logic [15:0] value_word,
    input  logic [15:0] index_word,
    input  logic [15:0] length_word,
    input  logic [3:0]  ep_number,
    input  logic        ep_is_in,
    input  logic [6:0]  done_len,
    input  logic        class_accepts,
    output cmd_t        cmd
);
    logic [7:0]  dev_len_reg;
    logic [11:0] conf_len_reg;
    logic [11:0] hid_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_len_reg  <= 8'd18;
            conf_len_reg <= 12'd9;
            hid_len_reg  <= 12'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DEVICE_LEN: dev_len_reg  <= cfg_data[7:0];
                REG_CONFIG_LEN: conf_len_reg <= cfg_data;
                REG_HID_LEN:    hid_len_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    function automatic logic [11:0] min12(input logic [15:0] a, input logic [11:0] b);
        min12 = (a < {4'd0, b}) ? a[11:0] : b;
    endfunction

    logic [4:0] recip;
    logic       dir_in;
    logic [7:0] dtype;
    logic [1:0] rtype;
    logic       itf_ok;

    always_comb
    begin
        recip  = request_type_byte[4:0];
        dir_in = request_type_byte[7];
        rtype  = request_type_byte[6:5];
        dtype  = value_word[15:8];
        itf_ok = ({24'd0, index_word[7:0]} < 32'(MAX_INTERFACES));
        cmd         = '0;
        cmd.op      = OP_NONE;
        cmd.src     = SRC_NONE;
        cmd.ep      = ep_number;
        cmd.dir_in  = ep_is_in;
        cmd.dlen    = done_len;
        cmd.accepts = class_accepts;
        cmd.rt      = request_type_byte;
        cmd.itf     = index_word[7:0];
        cmd.addr    = value_word[6:0];
        cmd.conf    = value_word[0];
        case (req_type)
            KIND_SETUP:
            begin
                cmd.op = OP_STALL;
                if (rtype == 2'd0)
                begin
                    if (recip == 5'd0)
                    begin
                        if (dir_in)
                        begin
                            if (request_code == REQ_GET_STATUS)
                            begin
                                cmd.op = OP_START_IN; cmd.src = SRC_ZERO; cmd.len = 12'd2;
                            end
                            else if (request_code == REQ_GET_DESCRIPTOR && dtype == 8'd1)
                            begin
                                cmd.op = OP_START_IN; cmd.src = SRC_DEVICE;
                                cmd.len = min12(length_word, {4'd0, dev_len_reg});
                            end
                            else if (request_code == REQ_GET_DESCRIPTOR && dtype == 8'd2)
                            begin
                                cmd.op = OP_START_IN; cmd.src = SRC_CONFIG;
                                cmd.len = min12(length_word, conf_len_reg);
                            end
                            else if (request_code == REQ_GET_DESCRIPTOR && dtype == 8'd3)
                            begin
                                cmd.op = OP_START_IN; cmd.src = SRC_STRING;
                                cmd.len = min12(length_word, STRING_DESC_LEN);
                            end
                        end
                        else if (request_code == REQ_SET_ADDRESS)
                            cmd.op = OP_SET_ADDR;
                        else if (request_code == REQ_SET_CONFIG && value_word[7:1] == 7'd0)
                            cmd.op = OP_SET_CONF;
                    end
                    else if (recip == 5'd1)
                    begin
                        if (!dir_in)
                        begin
                            if (request_code == REQ_SET_INTERFACE && itf_ok && class_accepts)
                                cmd.op = OP_ACK;
                        end
                        else if (request_code == REQ_GET_STATUS)
                        begin
                            cmd.op = OP_START_IN; cmd.src = SRC_ZERO; cmd.len = 12'd2;
                        end
                        else if (request_code == REQ_GET_DESCRIPTOR && dtype == 8'h22
                                 && hid_len_reg != 12'd0)
                        begin
                            cmd.op = OP_START_IN; cmd.src = SRC_HID;
                            cmd.len = min12(length_word, hid_len_reg);
                        end
                    end
                    else if (recip == 5'd2)
                    begin
                        if (request_code == REQ_CLEAR_FEATURE && index_word == 16'h0082
                            && NUM_ENDPOINTS > 2)
                            cmd.op = OP_CLEAR_EP2;
                    end
                end
                else if (rtype != 2'd3 && itf_ok)
                begin
                    if (dir_in)
                        cmd.op = OP_FWD_IN;
                    else if (length_word == 16'd0)
                        cmd.op = OP_FWD_OUT0;
                    else if (length_word <= 16'(MAX_PACKET))
                    begin
                        cmd.op = OP_ARM_DATA; cmd.len = length_word[11:0];
                    end
                end
            end
            KIND_DONE:
            begin
                if ({28'd0, ep_number} < 32'(NUM_ENDPOINTS))
                begin
                    if (ep_number != 4'd0)
                        cmd.op = OP_NOTIFY_EP;
                    else if (ep_is_in)
                        cmd.op = OP_EP0_IN_DONE;
                    else if (done_len != 7'd0)
                        cmd.op = OP_EP0_OUT_DONE;
                end
            end
            KIND_RESET: cmd.op = OP_BUS_RESET;
            default: cmd.op = OP_NONE;
        endcase
    end
endmodule

FILE: rtl/ep0_queue.sv
// Small FIFO between the classifier and the sequencer
module ep0_queue
    import ep0_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;

    assign full  = (cnt_reg == (AW+1)'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign rdata = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
            mem_reg[wp_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end
        else
        begin
            if (push && !full)
                wp_reg <= (wp_reg == AW'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
            if (pop && !empty)
                rp_reg <= (rp_reg == AW'(DEPTH-1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(push && !full) - (AW+1)'(pop && !empty);
        end
    end
endmodule

FILE: rtl/ep0_back.sv
// Back end: executes classified commands and emits up to three results
module ep0_back
    import ep0_pkg::*;
#(
    parameter int MAX_PACKET    = MAX_PACKET_DEF,
    parameter int NUM_ENDPOINTS = NUM_ENDPOINTS_DEF
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  cmd_t  cmd,
    input  logic  cmd_empty,
    output logic  cmd_pop,
    output res_t  res,
    output logic  res_valid,
    input  logic  res_ready
);
    localparam logic [6:0] MP = 7'(MAX_PACKET);

    logic [2:0]  src_reg, src_next;
    logic [11:0] total_reg, total_next;
    logic [11:0] sent_reg, sent_next;
    logic [NUM_ENDPOINTS-1:0] tin_reg, tin_next, tout_reg, tout_next;
    logic [6:0]  paddr_reg, paddr_next;
    logic        awt_reg, awt_next;
    logic        conf_reg, conf_next;
    logic [7:0]  srt_reg, srt_next;
    logic [7:0]  sitf_reg, sitf_next;
    // last EP0 IN packet of the transfer was a full one
    logic        lfull_reg, lfull_next;
    bstate_t     st_reg, st_next;
    res_t        r0, r1, r2, r1_reg, r1_next, r2_reg, r2_next;
    logic [1:0]  n_res;

    // output register
    res_t        out_reg, out_next;
    logic        ov_reg, ov_next;
    logic        load;

    function automatic res_t blank();
        res_t r;
        r = '0;
        r.data_source = SRC_NONE;
        return r;
    endfunction

    logic [11:0] rem, newsent;
    logic [6:0]  psize;
    logic        tog0;

    assign res       = out_reg;
    assign res_valid = ov_reg;
    assign load      = !ov_reg || res_ready;

    always_comb
    begin
        src_next = src_reg; total_next = total_reg; sent_next = sent_reg;
        tin_next = tin_reg; tout_next = tout_reg; paddr_next = paddr_reg;
        awt_next = awt_reg; conf_next = conf_reg; srt_next = srt_reg;
        sitf_next = sitf_reg; lfull_next = lfull_reg;
        r0 = blank(); r1 = blank(); r2 = blank(); n_res = 2'd0;
        rem = '0; psize = '0; newsent = '0; tog0 = 1'b0;
        case (cmd.op)
            OP_STALL:
            begin
                r0.action = ACT_STALL; n_res = 2'd1;
            end
            OP_START_IN, OP_SET_ADDR, OP_SET_CONF, OP_ACK:
            begin
                if (cmd.op == OP_START_IN)
                begin
                    src_next = cmd.src; total_next = cmd.len;
                end
                else
                begin
                    src_next = SRC_NONE; total_next = '0;
                end
                if (cmd.op == OP_SET_ADDR)
                begin
                    paddr_next = cmd.addr; awt_next = 1'b1;
                end
                if (cmd.op == OP_SET_CONF)
                    conf_next = cmd.conf;
                psize = (total_next > 12'(MAX_PACKET)) ? MP : total_next[6:0];
                r0.action = ACT_SEND_IN; r0.data_source = src_next;
                r0.packet_len = psize; r0.data_pid = 1'b1; r0.target_in = 1'b1;
                tin_next[0] = 1'b0; sent_next = {5'd0, psize};
                lfull_next = (psize == MP);
                n_res = 2'd1;
            end
            OP_CLEAR_EP2:
            begin
                r0.action = ACT_SEND_IN; r0.data_source = SRC_ZERO;
                r0.packet_len = CLEAR_EP_LEN; r0.target_ep = 4'd2; r0.target_in = 1'b1;
                r1.action = ACT_ARM_OUT; r1.packet_len = CLEAR_EP_LEN; r1.target_ep = 4'd2;
                tin_next[2 % NUM_ENDPOINTS] = 1'b1;
                tout_next[2 % NUM_ENDPOINTS] = 1'b1;
                r2.action = ACT_SEND_IN; r2.data_pid = 1'b1; r2.target_in = 1'b1;
                tin_next[0] = 1'b0;
                src_next = SRC_NONE; total_next = '0; sent_next = '0;
                n_res = 2'd3;
            end
            OP_FWD_IN:
            begin
                r0.action = ACT_FWD_REQ; r0.target_in = 1'b1; n_res = 2'd1;
                if (!cmd.accepts)
                begin
                    r1.action = ACT_STALL; n_res = 2'd2;
                end
            end
            OP_FWD_OUT0:
            begin
                r0.action = ACT_FWD_REQ; n_res = 2'd2;
                if (cmd.accepts)
                begin
                    r1.action = ACT_SEND_IN; r1.data_pid = 1'b1; r1.target_in = 1'b1;
                    tin_next[0] = 1'b0; src_next = SRC_NONE;
                    total_next = '0; sent_next = '0;
                end
                else
                    r1.action = ACT_STALL;
            end
            OP_ARM_DATA:
            begin
                srt_next = cmd.rt; sitf_next = cmd.itf;
                r0.action = ACT_ARM_OUT; r0.packet_len = cmd.len[6:0]; r0.data_pid = 1'b1;
                tout_next[0] = 1'b0; n_res = 2'd1;
            end
            OP_EP0_IN_DONE:
            begin
                n_res = 2'd1;
                if (awt_reg)
                begin
                    r0.action = ACT_ADDRESS; r0.new_address = paddr_reg; awt_next = 1'b0;
                end
                else if (sent_reg < total_reg || (total_reg != '0 && lfull_reg))
                begin
                    if (sent_reg < total_reg)
                    begin
                        rem = total_reg - sent_reg;
                        psize = (rem > 12'(MAX_PACKET)) ? MP : rem[6:0];
                        newsent = sent_reg + {5'd0, psize};
                        r0.data_source = src_reg; r0.byte_offset = sent_reg;
                        lfull_next = (psize == MP);
                    end
                    else
                    begin
                        // exact multiple of a packet: close with a zero-length packet
                        src_next = SRC_NONE; total_next = '0; newsent = '0;
                        lfull_next = 1'b0;
                    end
                    tog0 = tin_reg[0];
                    r0.action = ACT_SEND_IN; r0.packet_len = psize; r0.data_pid = tog0;
                    r0.target_in = 1'b1; tin_next[0] = ~tog0; sent_next = newsent;
                end
                else
                begin
                    r0.action = ACT_ARM_OUT; r0.data_pid = 1'b1; tout_next[0] = 1'b0;
                    r1.action = ACT_NOTIFY; r1.target_in = 1'b1; n_res = 2'd2;
                end
            end
            OP_EP0_OUT_DONE:
            begin
                n_res = 2'd1; r0.action = ACT_STALL;
                if (srt_reg[6:5] == 2'd1 || srt_reg[6:5] == 2'd2)
                begin
                    r0.action = ACT_FWD_DATA;
                    r0.packet_len = (cmd.dlen > MP) ? MP : cmd.dlen;
                    n_res = 2'd2;
                    if (cmd.accepts)
                    begin
                        r1.action = ACT_SEND_IN; r1.data_pid = 1'b1; r1.target_in = 1'b1;
                        tin_next[0] = 1'b0; src_next = SRC_NONE;
                        total_next = '0; sent_next = '0;
                    end
                    else
                        r1.action = ACT_STALL;
                end
            end
            OP_NOTIFY_EP:
            begin
                r0.action = ACT_NOTIFY; r0.target_ep = cmd.ep; r0.target_in = cmd.dir_in;
                r0.packet_len = cmd.dir_in ? 7'd0 : cmd.dlen; n_res = 2'd1;
            end
            OP_BUS_RESET:
            begin
                paddr_next = '0; awt_next = 1'b0; conf_next = 1'b0;
                tin_next = '0; tout_next = '0;
                r0.action = ACT_ADDRESS; n_res = 2'd1;
            end
            default: n_res = 2'd0;
        endcase
        r0.is_configured = conf_next; r1.is_configured = conf_next;
        r2.is_configured = conf_next;
        r0.last_result = (n_res == 2'd1);
        r1.last_result = (n_res == 2'd2);
        r2.last_result = 1'b1;
    end

    // sequencer: command taken in IDLE, further results drained in R1/R2
    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            ST_IDLE:
                if (!cmd_empty && load && n_res > 2'd1)
                    st_next = ST_R1;
            ST_R1:
                if (load)
                    st_next = r2_reg.action != ACT_NONE ? ST_R2 : ST_IDLE;
            ST_R2:
                if (load)
                    st_next = ST_IDLE;
            default: st_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_pop  = 1'b0;
        out_next = out_reg;
        ov_next  = ov_reg && !res_ready;
        r1_next  = r1_reg;
        r2_next  = r2_reg;
        case (st_reg)
            ST_IDLE:
                if (!cmd_empty && load)
                begin
                    cmd_pop = 1'b1;
                    if (n_res != 2'd0)
                    begin
                        out_next = r0; ov_next = 1'b1;
                    end
                    r1_next = r1;
                    r2_next = (n_res == 2'd3) ? r2 : blank();
                end
            ST_R1:
                if (load)
                begin
                    out_next = r1_reg; ov_next = 1'b1;
                end
            ST_R2:
                if (load)
                begin
                    out_next = r2_reg; ov_next = 1'b1;
                end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        r1_reg  <= r1_next;
        r2_reg  <= r2_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE; ov_reg <= 1'b0;
            src_reg <= SRC_NONE; total_reg <= '0; sent_reg <= '0;
            tin_reg <= '0; tout_reg <= NUM_ENDPOINTS'(1);
            paddr_reg <= '0; awt_reg <= 1'b0; conf_reg <= 1'b0;
            srt_reg <= '0; sitf_reg <= '0; lfull_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next; ov_reg <= ov_next;
            if (cmd_pop)
            begin
                src_reg <= src_next; total_reg <= total_next; sent_reg <= sent_next;
                tin_reg <= tin_next; tout_reg <= tout_next;
                paddr_reg <= paddr_next; awt_reg <= awt_next; conf_reg <= conf_next;
                srt_reg <= srt_next; sitf_reg <= sitf_next; lfull_reg <= lfull_next;
            end
        end
    end
endmodule

FILE: rtl/usb_ep0_control_sequencer_unit.sv
// Top level of the USB EP0 control sequencer
// An event is decoded combinationally and written into a two-entry command
// queue at the edge that accepts it; the back end takes the command when it is
// idle and its output register can load, and loads its first result into
// that register, which drives the ports. Further results follow one per cycle
// (up to three per event) while pop keeps up. An event that yields no result
// is still taken from the queue by the back end. The input stalls only while
// the queue is full. Config writes land in the front end at once.
module usb_ep0_control_sequencer_unit
    import ep0_pkg::*;
#(
    parameter int MAX_PACKET     = MAX_PACKET_DEF,
    parameter int NUM_ENDPOINTS  = NUM_ENDPOINTS_DEF,
    parameter int MAX_INTERFACES = MAX_INTERFACES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  req_type,
    input  logic [7:0]  request_type_byte,
    input  logic [7:0]  request_code,
    input  logic [15:0] value_word,
    input  logic [15:0] index_word,
    input  logic [15:0] length_word,
    input  logic [3:0]  ep_number,
    input  logic        ep_is_in,
    input  logic [6:0]  done_len,
    input  logic        class_accepts,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  action,
    output logic [2:0]  data_source,
    output logic [11:0] byte_offset,
    output logic [6:0]  packet_len,
    output logic        data_pid,
    output logic [3:0]  target_ep,
    output logic        target_in,
    output logic [6:0]  new_address,
    output logic        is_configured,
    output logic        last_result
);
    cmd_t cmd_in, cmd_out;
    logic cmd_empty, cmd_pop, res_valid;
    res_t res;

    ep0_front #(.MAX_PACKET(MAX_PACKET), .NUM_ENDPOINTS(NUM_ENDPOINTS),
                .MAX_INTERFACES(MAX_INTERFACES)) u_front (
        .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data, .req_type, .request_type_byte,
        .request_code, .value_word, .index_word, .length_word, .ep_number,
        .ep_is_in, .done_len, .class_accepts, .cmd(cmd_in));

    ep0_queue #(.WIDTH($bits(cmd_t)), .DEPTH(2)) u_queue (
        .clk, .rst_n, .push, .wdata(cmd_in), .full, .pop(cmd_pop),
        .rdata(cmd_out), .empty(cmd_empty));

    ep0_back #(.MAX_PACKET(MAX_PACKET), .NUM_ENDPOINTS(NUM_ENDPOINTS)) u_back (
        .clk, .rst_n, .cmd(cmd_out), .cmd_empty, .cmd_pop, .res, .res_valid,
        .res_ready(pop));

    assign empty         = !res_valid;
    assign action        = res.action;
    assign data_source   = res.data_source;
    assign byte_offset   = res.byte_offset;
    assign packet_len    = res.packet_len;
    assign data_pid      = res.data_pid;
    assign target_ep     = res.target_ep;
    assign target_in     = res.target_in;
    assign new_address   = res.new_address;
    assign is_configured = res.is_configured;
    assign last_result   = res.last_result;
endmodule

FILE: rtl/ep0_checker.sv
// Port-level checker for the EP0 control sequencer
`include "assert_macros.svh"
module ep0_checker
    import ep0_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       empty,
    input logic       pop,
    input logic [2:0] action,
    input logic [2:0] data_source,
    input logic [6:0] packet_len,
    input logic       target_in
);
    `CHK_NEXT(a_hold, clk, rst_n, !empty && !pop, !empty && $stable(action), "result dropped")
    `CHK_IMPLY(a_stall, clk, rst_n, !empty && action == ACT_STALL, data_source == SRC_NONE && !target_in, "stall fields")
    `CHK_IMPLY(a_len, clk, rst_n, !empty, packet_len <= 7'd64, "packet too long")
    `CHK_IMPLY(a_noact, clk, rst_n, !empty, action != ACT_NONE, "empty action")
endmodule

bind usb_ep0_control_sequencer_unit ep0_checker u_chk (
    .clk, .rst_n, .empty, .pop, .action, .data_source, .packet_len, .target_in);

FILE: tb/ep0_control_checker.sv
// Checker for the EP0 control sequencer: predicts endpoint actions and compares
`timescale 1ns / 1ps
module ep0_control_checker
    import ep0_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data,
    input  logic        push,
    input  logic        full,
    input  logic [1:0]  req_type,
    input  logic [7:0]  request_type_byte,
    input  logic [7:0]  request_code,
    input  logic [15:0] value_word,
    input  logic [15:0] index_word,
    input  logic [15:0] length_word,
    input  logic [3:0]  ep_number,
    input  logic        ep_is_in,
    input  logic [6:0]  done_len,
    input  logic        class_accepts,
    input  logic        empty,
    input  logic        pop,
    input  logic [2:0]  action,
    input  logic [2:0]  data_source,
    input  logic [11:0] byte_offset,
    input  logic [6:0]  packet_len,
    input  logic        data_pid,
    input  logic [3:0]  target_ep,
    input  logic        target_in,
    input  logic [6:0]  new_address,
    input  logic        is_configured,
    input  logic        last_result,
    output int          errors,
    output int          pending
);
    localparam int MPS = MAX_PACKET_DEF;

    // mirrored configuration and endpoint state
    logic [7:0]  dev_len;
    logic [11:0] cfg_len;
    logic [11:0] hid_len;
    logic [2:0]  xfer_src;
    logic [11:0] xfer_total;
    logic [11:0] xfer_sent;
    logic [15:0] tog_in;
    logic [15:0] tog_out;
    logic [6:0]  pend_addr;
    logic        addr_waiting;
    logic        configured;
    logic [7:0]  saved_rt;

    res_t actions_expected[$];
    res_t evt_acts[3];
    int   evt_cnt;

    assign pending = actions_expected.size();

    function automatic void add_act(logic [2:0] act, logic [2:0] src, logic [11:0] off,
                                    logic [6:0] len, logic pid, logic [3:0] ep,
                                    logic dir, logic [6:0] addr);
        res_t r;
        if (evt_cnt >= 3)
            return;
        r = '0;
        r.action = act;
        r.data_source = src;
        r.byte_offset = off;
        r.packet_len = len;
        r.data_pid = pid;
        r.target_ep = ep;
        r.target_in = dir;
        r.new_address = addr;
        evt_acts[evt_cnt] = r;
        evt_cnt++;
    endfunction

    function automatic void stall();
        add_act(ACT_STALL, SRC_NONE, 0, 0, 0, 0, 0, 0);
    endfunction

    function automatic void next_packet();
        logic [11:0] rem;
        logic [11:0] size;
        rem = xfer_total - xfer_sent;
        size = (rem > MPS) ? 12'(MPS) : rem;
        add_act(ACT_SEND_IN, xfer_src, xfer_sent, size[6:0], tog_in[0], 0, 1, 0);
        tog_in[0] = ~tog_in[0];
        xfer_sent = xfer_sent + size;
    endfunction

    function automatic void begin_in(logic [2:0] src, int unsigned len);
        xfer_src = src;
        xfer_total = len[11:0];
        xfer_sent = '0;
        tog_in[0] = 1'b1;
        next_packet();
    endfunction

    function automatic int unsigned min_u(int unsigned a, int unsigned b);
        return (a < b) ? a : b;
    endfunction

    function automatic void do_standard(logic [7:0] rt, logic [7:0] code, logic [15:0] val,
                                        logic [15:0] idx, logic [15:0] wlen, logic acc);
        logic [4:0] recip;
        logic [7:0] dtype;
        recip = rt[4:0];
        dtype = val[15:8];
        if (recip == 0) begin
            if (rt[7]) begin
                if (code == REQ_GET_STATUS)
                    begin_in(SRC_ZERO, 2);
                else if (code == REQ_GET_DESCRIPTOR && dtype == 1)
                    begin_in(SRC_DEVICE, min_u(wlen, dev_len));
                else if (code == REQ_GET_DESCRIPTOR && dtype == 2)
                    begin_in(SRC_CONFIG, min_u(wlen, cfg_len));
                else if (code == REQ_GET_DESCRIPTOR && dtype == 3)
                    begin_in(SRC_STRING, min_u(wlen, STRING_DESC_LEN));
                else
                    stall();
            end else if (code == REQ_SET_ADDRESS) begin
                pend_addr = val[6:0];
                addr_waiting = 1'b1;
                begin_in(SRC_NONE, 0);
            end else if (code == REQ_SET_CONFIG && val[7:0] <= 1) begin
                configured = val[0];
                begin_in(SRC_NONE, 0);
            end else begin
                stall();
            end
        end else if (recip == 1) begin
            if (!rt[7]) begin
                if (code == REQ_SET_INTERFACE && idx[7:0] < MAX_INTERFACES_DEF && acc)
                    begin_in(SRC_NONE, 0);
                else
                    stall();
            end else if (code == REQ_GET_STATUS) begin
                begin_in(SRC_ZERO, 2);
            end else if (code == REQ_GET_DESCRIPTOR && dtype == 8'h22 && hid_len != 0) begin
                begin_in(SRC_HID, min_u(wlen, hid_len));
            end else begin
                stall();
            end
        end else if (recip == 2) begin
            if (code == REQ_CLEAR_FEATURE && idx == 16'h0082) begin
                add_act(ACT_SEND_IN, SRC_ZERO, 0, CLEAR_EP_LEN, 1'b0, 2, 1, 0);
                tog_in[2] = 1'b1;
                add_act(ACT_ARM_OUT, SRC_NONE, 0, CLEAR_EP_LEN, 1'b0, 2, 0, 0);
                tog_out[2] = 1'b1;
                begin_in(SRC_NONE, 0);
            end else begin
                stall();
            end
        end else begin
            stall();
        end
    endfunction

    function automatic void do_class(logic [7:0] rt, logic [15:0] idx, logic [15:0] wlen,
                                     logic acc);
        if (idx[7:0] >= MAX_INTERFACES_DEF) begin
            stall();
        end else if (rt[7]) begin
            add_act(ACT_FWD_REQ, SRC_NONE, 0, 0, 0, 0, 1, 0);
            if (!acc)
                stall();
        end else if (wlen == 0) begin
            add_act(ACT_FWD_REQ, SRC_NONE, 0, 0, 0, 0, 0, 0);
            if (acc)
                begin_in(SRC_NONE, 0);
            else
                stall();
        end else if (wlen > MPS) begin
            stall();
        end else begin
            saved_rt = rt;
            add_act(ACT_ARM_OUT, SRC_NONE, 0, wlen[6:0], 1'b1, 0, 0, 0);
            tog_out[0] = 1'b0;
        end
    endfunction

    function automatic void do_done(logic [3:0] ep, logic dir, logic [6:0] dlen, logic acc);
        if (ep != 0) begin
            add_act(ACT_NOTIFY, SRC_NONE, 0, dir ? 7'd0 : dlen, 0, ep, dir, 0);
        end else if (dir) begin
            if (addr_waiting) begin
                add_act(ACT_ADDRESS, SRC_NONE, 0, 0, 0, 0, 0, pend_addr);
                addr_waiting = 1'b0;
            end else if (xfer_sent < xfer_total) begin
                next_packet();
            end else if (xfer_total != 0 && xfer_total[5:0] == 0) begin
                // exact multiple of a packet: close with a zero-length packet
                xfer_src = SRC_NONE;
                xfer_total = '0;
                xfer_sent = '0;
                next_packet();
            end else begin
                add_act(ACT_ARM_OUT, SRC_NONE, 0, 0, 1'b1, 0, 0, 0);
                tog_out[0] = 1'b0;
                add_act(ACT_NOTIFY, SRC_NONE, 0, 0, 0, 0, 1, 0);
            end
        end else if (dlen != 0) begin
            if (saved_rt[6:5] == 2'b01 || saved_rt[6:5] == 2'b10) begin
                add_act(ACT_FWD_DATA, SRC_NONE, 0, (dlen > MPS) ? 7'(MPS) : dlen,
                        0, 0, 0, 0);
                if (acc)
                    begin_in(SRC_NONE, 0);
                else
                    stall();
            end else begin
                stall();
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        res_t got;
        res_t exp_r;
        if (!rst_n) begin
            dev_len = 8'd18;
            cfg_len = 12'd9;
            hid_len = 12'd0;
            xfer_src = SRC_NONE;
            xfer_total = '0;
            xfer_sent = '0;
            tog_in = '0;
            tog_out = 16'h0001;
            pend_addr = '0;
            addr_waiting = 1'b0;
            configured = 1'b0;
            saved_rt = '0;
            actions_expected.delete();
            errors = 0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_DEVICE_LEN)
                    dev_len = cfg_data[7:0];
                else if (cfg_index == REG_CONFIG_LEN)
                    cfg_len = cfg_data;
                else if (cfg_index == REG_HID_LEN)
                    hid_len = cfg_data;
            end
            if (pop && !empty) begin
                got = {action, data_source, byte_offset, packet_len, data_pid, target_ep,
                       target_in, new_address, is_configured, last_result};
                if (actions_expected.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("%t unexpected transaction: %p", $realtime, got);
                end else begin
                    exp_r = actions_expected.pop_front();
                    if (got !== exp_r) begin
                        errors++;
                        if (errors <= 10)
                            $display("%t mismatch: expected %p actual %p",
                                     $realtime, exp_r, got);
                    end
                end
            end
            if (push && !full) begin
                evt_cnt = 0;
                if (req_type == KIND_SETUP) begin
                    if (request_type_byte[6:5] == 2'b00)
                        do_standard(request_type_byte, request_code, value_word,
                                    index_word, length_word, class_accepts);
                    else if (request_type_byte[6:5] != 2'b11)
                        do_class(request_type_byte, index_word, length_word, class_accepts);
                    else
                        stall();
                end else if (req_type == KIND_DONE) begin
                    do_done(ep_number, ep_is_in, done_len, class_accepts);
                end else if (req_type == KIND_RESET) begin
                    pend_addr = '0;
                    addr_waiting = 1'b0;
                    configured = 1'b0;
                    tog_in = '0;
                    tog_out = '0;
                    add_act(ACT_ADDRESS, SRC_NONE, 0, 0, 0, 0, 0, 0);
                end
                for (int k = 0; k < evt_cnt; k++) begin
                    evt_acts[k].is_configured = configured;
                    evt_acts[k].last_result = (k == evt_cnt - 1);
                    actions_expected.push_back(evt_acts[k]);
                end
            end
        end
    end
endmodule

FILE: tb/usb_ep0_control_sequencer_unit_tb.sv
// Stimulus and verdict for the EP0 control sequencer
`timescale 1ns / 1ps
module usb_ep0_control_sequencer_unit_tb;
    import ep0_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [11:0] cfg_data;
    logic        push;
    logic        full;
    logic [1:0]  req_type;
    logic [7:0]  request_type_byte;
    logic [7:0]  request_code;
    logic [15:0] value_word;
    logic [15:0] index_word;
    logic [15:0] length_word;
    logic [3:0]  ep_number;
    logic        ep_is_in;
    logic [6:0]  done_len;
    logic        class_accepts;
    logic        empty;
    logic        pop;
    logic [2:0]  action;
    logic [2:0]  data_source;
    logic [11:0] byte_offset;
    logic [6:0]  packet_len;
    logic        data_pid;
    logic [3:0]  target_ep;
    logic        target_in;
    logic [6:0]  new_address;
    logic        is_configured;
    logic        last_result;
    int          errors;
    int          pending;

    int burst_left;
    int sent_events;
    int hold_request;

    usb_ep0_control_sequencer_unit u_dut (.*);
    ep0_control_checker u_chk (.*);

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

    // result side: stall pattern changes every stretch; long hold-off on request
    initial begin
        int mode;
        int hold;
        pop = 1'b0;
        forever begin
            mode = $urandom_range(0, 2);
            repeat ($urandom_range(20, 120)) begin
                @(negedge clk);
                if (hold_request > 0) begin
                    hold = hold_request;
                    hold_request = 0;
                    pop = 1'b0;
                    repeat (hold) @(negedge clk);
                end
                case (mode)
                    0: pop = 1'b1;
                    1: pop = ($urandom_range(0, 3) != 0);
                    default: pop = ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task automatic issue(logic [1:0] kind, logic [7:0] rt, logic [7:0] code,
                         logic [15:0] val, logic [15:0] idx, logic [15:0] wlen,
                         logic [3:0] ep, logic dir, logic [6:0] dlen, logic acc);
        if (burst_left <= 0) begin
            push = 1'b0;
            repeat ($urandom_range(0, 8)) @(negedge clk);
            burst_left = $urandom_range(1, 12);
        end
        req_type = kind;
        request_type_byte = rt;
        request_code = code;
        value_word = val;
        index_word = idx;
        length_word = wlen;
        ep_number = ep;
        ep_is_in = dir;
        done_len = dlen;
        class_accepts = acc;
        push = 1'b1;
        do @(posedge clk); while (full);
        @(negedge clk);
        burst_left--;
        sent_events++;
    endtask

    task automatic setup(logic [7:0] rt, logic [7:0] code, logic [15:0] val,
                         logic [15:0] idx, logic [15:0] wlen, logic acc);
        issue(KIND_SETUP, rt, code, val, idx, wlen, 4'($urandom), 1'($urandom),
              7'($urandom_range(0, 64)), acc);
    endtask

    task automatic buf_done(logic [3:0] ep, logic dir, logic [6:0] dlen, logic acc);
        issue(KIND_DONE, 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), ep, dir, dlen, acc);
    endtask

    // wait until every expected transaction is out, plus the no-result slack
    task automatic drain();
        push = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    task automatic write_regs(logic [7:0] dev, logic [11:0] conf, logic [11:0] hid);
        cfg_we = 1'b1;
        cfg_index = REG_DEVICE_LEN;
        cfg_data = {4'h0, dev};
        @(negedge clk);
        cfg_index = REG_CONFIG_LEN;
        cfg_data = conf;
        @(negedge clk);
        cfg_index = REG_HID_LEN;
        cfg_data = hid;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic rand_scenario();
        logic [7:0] rt;
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0, 1: begin
                setup(8'h80 | 8'($urandom_range(0, 1)), REQ_GET_DESCRIPTOR,
                      {8'($urandom_range(1, 3)), 8'($urandom)}, 16'($urandom),
                      ($urandom_range(0, 7) == 0) ? 16'($urandom) :
                      16'($urandom_range(0, 300)), 1'($urandom));
                repeat ($urandom_range(1, 7))
                    buf_done(4'd0, 1'b1, 7'($urandom_range(0, 64)), 1'($urandom));
            end
            2: begin
                setup(8'h81, REQ_GET_DESCRIPTOR, {8'h22, 8'($urandom)}, 16'($urandom),
                      16'($urandom_range(0, 200)), 1'($urandom));
                repeat ($urandom_range(1, 5))
                    buf_done(4'd0, 1'b1, 7'($urandom_range(0, 64)), 1'($urandom));
            end
            3: begin
                setup(8'h00, REQ_SET_ADDRESS, 16'($urandom), 16'($urandom), 16'($urandom),
                      1'($urandom));
                repeat ($urandom_range(1, 3))
                    buf_done(4'd0, 1'b1, 7'($urandom_range(0, 64)), 1'($urandom));
            end
            4: begin
                setup({1'b0, 7'($urandom_range(0, 2))}, 8'($urandom_range(0, 12)),
                      {8'($urandom), 8'($urandom_range(0, 2))}, $urandom_range(0, 3) == 0 ?
                      16'h0082 : 16'($urandom), 16'($urandom), 1'($urandom));
                buf_done(4'd0, 1'b1, 7'($urandom_range(0, 64)), 1'($urandom));
            end
            5: begin
                rt = {1'b0, 2'($urandom_range(1, 2)), 5'($urandom)};
                setup(rt, 8'($urandom), 16'($urandom),
                      {8'($urandom), 8'($urandom_range(0, 9))},
                      16'($urandom_range(0, 70)), 1'($urandom));
                buf_done(4'd0, 1'b0, 7'($urandom_range(0, 64)), 1'($urandom));
                if ($urandom_range(0, 1))
                    buf_done(4'd0, 1'b1, 7'($urandom_range(0, 64)), 1'($urandom));
            end
            6: begin
                setup({1'b1, 2'($urandom_range(1, 2)), 5'($urandom)}, 8'($urandom),
                      16'($urandom), {8'($urandom), 8'($urandom_range(0, 9))},
                      16'($urandom), 1'($urandom));
                buf_done(4'd0, 1'b1, 7'($urandom_range(0, 64)), 1'($urandom));
            end
            7: buf_done(4'($urandom), 1'($urandom), 7'($urandom_range(0, 64)), 1'($urandom));
            default: begin
                issue($urandom_range(0, 9) == 0 ? KIND_RESET : 2'($urandom_range(0, 1)),
                      8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), 4'($urandom), 1'($urandom),
                      7'($urandom_range(0, 64)), 1'($urandom));
            end
        endcase
    endtask

    initial begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_DEVICE_LEN;
        cfg_data = '0;
        push = 1'b0;
        req_type = KIND_SETUP;
        request_type_byte = '0;
        request_code = '0;
        value_word = '0;
        index_word = '0;
        length_word = '0;
        ep_number = '0;
        ep_is_in = 1'b0;
        done_len = '0;
        class_accepts = 1'b0;
        burst_left = 0;
        sent_events = 0;
        hold_request = 0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: request kinds and corners at reset lengths
        setup(8'h80, REQ_GET_STATUS, 16'h0000, 16'h0000, 16'h0002, 1'b1);
        setup(8'h80, REQ_GET_DESCRIPTOR, 16'h0100, 16'h0000, 16'hFFFF, 1'b0);
        buf_done(4'd0, 1'b1, 7'd64, 1'b0);
        setup(8'h80, REQ_GET_DESCRIPTOR, 16'h0200, 16'h0000, 16'h0040, 1'b0);
        setup(8'h80, REQ_GET_DESCRIPTOR, 16'h0300, 16'h0000, 16'h0000, 1'b0);
        setup(8'h80, REQ_GET_DESCRIPTOR, 16'hFF00, 16'h0000, 16'h0010, 1'b0);
        setup(8'h00, REQ_SET_ADDRESS, 16'hFFFF, 16'h0000, 16'h0000, 1'b0);
        buf_done(4'd0, 1'b1, 7'd0, 1'b0);
        setup(8'h00, REQ_SET_CONFIG, 16'h0001, 16'h0000, 16'h0000, 1'b0);
        setup(8'h00, REQ_SET_CONFIG, 16'h0002, 16'h0000, 16'h0000, 1'b0);
        setup(8'h01, REQ_SET_INTERFACE, 16'h0000, 16'h0007, 16'h0000, 1'b1);
        setup(8'h01, REQ_SET_INTERFACE, 16'h0000, 16'h0008, 16'h0000, 1'b1);
        setup(8'h81, REQ_GET_DESCRIPTOR, 16'h2200, 16'h0000, 16'h0040, 1'b1);
        setup(8'h02, REQ_CLEAR_FEATURE, 16'h0000, 16'h0082, 16'h0000, 1'b0);
        setup(8'h02, REQ_CLEAR_FEATURE, 16'h0000, 16'h0182, 16'h0000, 1'b0);
        setup(8'hA1, 8'hFF, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b0);
        setup(8'h21, 8'h09, 16'h0000, 16'h0001, 16'h0000, 1'b1);
        setup(8'h41, 8'h01, 16'h0000, 16'h0001, 16'h0041, 1'b1);
        setup(8'h21, 8'h09, 16'h0000, 16'hFF02, 16'h0040, 1'b1);
        buf_done(4'd0, 1'b0, 7'd0, 1'b1);
        buf_done(4'd0, 1'b0, 7'd64, 1'b1);
        setup(8'hE0, 8'h00, 16'h0000, 16'h0000, 16'h0000, 1'b1);
        buf_done(4'hF, 1'b0, 7'd64, 1'b1);
        issue(KIND_RESET, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'hF, 1'b1, 7'd64, 1'b1);
        buf_done(4'd0, 1'b0, 7'd5, 1'b1);
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: write_regs(8'd255, 12'd4095, 12'd4095);
                1: write_regs(8'd0, 12'd0, 12'd0);
                2: write_regs(8'd64, 12'd128, 12'd100);
                default: write_regs(8'($urandom), 12'($urandom_range(0, 300)),
                                    12'($urandom_range(1, 200)));
            endcase
            if (phase == 1)
                hold_request = 300;
            while (sent_events < 25 + 60 * (phase + 1))
                rand_scenario();
            drain();
        end

        if (errors == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+rtl
rtl/ep0_pkg.sv
rtl/ep0_front.sv
rtl/ep0_queue.sv
rtl/ep0_back.sv
rtl/usb_ep0_control_sequencer_unit.sv
rtl/ep0_checker.sv
tb/ep0_control_checker.sv
tb/usb_ep0_control_sequencer_unit_tb.sv
